FILE: rtl/bhls_pkg.sv
package bhls_pkg;

    localparam int NUM_LOCATIONS = 8;
    localparam int CAPACITY      = 8;

    localparam int CMD_W   = 1;
    localparam int LOCIN_W = 8;
    localparam int LVL_W   = 14;
    localparam int CLS_W   = 2;
    localparam int OUTC_W  = 2;
    localparam int ENTRY_W = 7;
    localparam int TIER_W  = 2;

    localparam int LOC_W   = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DEPTH   = NUM_LOCATIONS * CAPACITY;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = $clog2(CAPACITY * ((1 << LVL_W) - 1) + 1);
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ANALYSE = 1'b1;

    localparam logic [OUTC_W-1:0] OUTCOME_DONE  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTCOME_RANGE = 2'd1;
    localparam logic [OUTC_W-1:0] OUTCOME_EMPTY = 2'd2;

    localparam logic [CLS_W-1:0] CLASS_RED    = 2'd0;
    localparam logic [CLS_W-1:0] CLASS_YELLOW = 2'd1;
    localparam logic [CLS_W-1:0] CLASS_GREEN  = 2'd2;

    localparam logic [TIER_W-1:0] TIER_LOW  = 2'd0;
    localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_HIGH = 2'd2;

    localparam logic [LVL_W-1:0] TIER_HIGH_MIN = 14'd8500;
    localparam logic [LVL_W-1:0] TIER_MID_MIN  = 14'd6000;

    typedef struct packed {
        logic capture;
        logic push_write;
        logic walk_start;
        logic walk_step;
        logic div_start;
        logic load_out;
    } bhls_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_push;
        logic cnt_zero;
        logic walk_last;
        logic div_busy;
        logic out_free;
    } bhls_stat_t;

endpackage

FILE: rtl/bhls_if.sv
interface bhls_req_if;
    logic                        valid;
    logic                        ready;
    logic [bhls_pkg::CMD_W-1:0]   cmd;
    logic [bhls_pkg::LOCIN_W-1:0] location;
    logic [bhls_pkg::LVL_W-1:0]   fill_level;
    logic [bhls_pkg::CLS_W-1:0]   level_class;

    modport source (output valid, output cmd, output location, output fill_level,
                    output level_class, input ready);
    modport sink (input valid, input cmd, input location, input fill_level,
                  input level_class, output ready);
endinterface

interface bhls_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bhls_pkg::OUTC_W-1:0]  outcome;
    logic [bhls_pkg::ENTRY_W-1:0] entry_count;
    logic [bhls_pkg::LVL_W-1:0]   mean_level;
    logic [bhls_pkg::CLS_W-1:0]   dominant_class;
    logic [bhls_pkg::TIER_W-1:0]  advice_tier;

    modport source (output valid, output outcome, output entry_count, output mean_level,
                    output dominant_class, output advice_tier, input ready);
    modport sink (input valid, input outcome, input entry_count, input mean_level,
                  input dominant_class, input advice_tier, output ready);
endinterface

FILE: rtl/bhls_div.sv
module bhls_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bhls_pkg::SUM_W-1:0]  dividend,
    input  logic [bhls_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic [bhls_pkg::LVL_W-1:0]  quotient
);
    import bhls_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            step_next = STEP_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            rem_next  = fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
            quo_next  = {quo_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = (step_reg != '0);
    assign quotient = LVL_W'(quo_reg);

endmodule

FILE: rtl/bhls_dp.sv
module bhls_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bhls_pkg::bhls_cmd_t           cmd_in,
    output bhls_pkg::bhls_stat_t          stat,
    input  logic [bhls_pkg::CMD_W-1:0]    req_cmd,
    input  logic [bhls_pkg::LOCIN_W-1:0]  req_location,
    input  logic [bhls_pkg::LVL_W-1:0]    req_fill_level,
    input  logic [bhls_pkg::CLS_W-1:0]    req_level_class,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [bhls_pkg::OUTC_W-1:0]   rsp_outcome,
    output logic [bhls_pkg::ENTRY_W-1:0]  rsp_entry_count,
    output logic [bhls_pkg::LVL_W-1:0]    rsp_mean_level,
    output logic [bhls_pkg::CLS_W-1:0]    rsp_dominant_class,
    output logic [bhls_pkg::TIER_W-1:0]   rsp_advice_tier
);
    import bhls_pkg::*;

    localparam int MEM_W = LVL_W + CLS_W;

    // captured request
    logic [CMD_W-1:0]   cmd_reg;
    logic [LOCIN_W-1:0] loc_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [CLS_W-1:0]   cls_reg;

    // per-location ring state
    logic [CNT_W-1:0]  fill_cnt_reg [NUM_LOCATIONS];
    logic [SLOT_W-1:0] oldest_reg [NUM_LOCATIONS];

    logic [MEM_W-1:0]  hist_mem [DEPTH];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;

    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [SLOT_W-1:0] walk_slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  red_reg;
    logic [CNT_W-1:0]  yel_reg;
    logic [CNT_W-1:0]  grn_reg;

    logic              out_valid_reg;
    logic [OUTC_W-1:0] outcome_reg;
    logic [ENTRY_W-1:0] count_out_reg;
    logic [LVL_W-1:0]  mean_out_reg;
    logic [CLS_W-1:0]  dom_out_reg;
    logic [TIER_W-1:0] tier_out_reg;

    logic [LOC_W-1:0]  loc_idx;
    logic              in_range;
    logic [CNT_W-1:0]  cur_cnt;
    logic [SLOT_W-1:0] cur_old;
    logic [CNT_W:0]    push_pos;
    logic [SLOT_W-1:0] push_slot;
    logic [CNT_W:0]    old_inc;
    logic [SLOT_W-1:0] old_adv;
    logic [CNT_W:0]    walk_inc;
    logic [SLOT_W-1:0] walk_adv;
    logic [ADDR_W-1:0] base_addr;
    logic              cnt_full;
    logic              div_busy;
    logic [LVL_W-1:0]  quotient;
    logic [CLS_W-1:0]  rd_class;
    logic [CLS_W-1:0]  dom;
    logic [TIER_W-1:0] tier;

    assign loc_idx  = loc_reg[LOC_W-1:0];
    assign in_range = ({1'b0, loc_reg} < (LOCIN_W + 1)'(NUM_LOCATIONS));
    assign cur_cnt  = fill_cnt_reg[loc_idx];
    assign cur_old  = oldest_reg[loc_idx];
    assign cnt_full = (cur_cnt == CNT_W'(CAPACITY));
    assign base_addr = ADDR_W'(ADDR_W'(loc_idx) * ADDR_W'(CAPACITY));

    always_comb
    begin
        push_pos = (CNT_W + 1)'(cur_old) + (CNT_W + 1)'(cur_cnt);
        if (push_pos >= (CNT_W + 1)'(CAPACITY))
        begin
            push_pos = push_pos - (CNT_W + 1)'(CAPACITY);
        end
        push_slot = cnt_full ? cur_old : SLOT_W'(push_pos);

        old_inc = (CNT_W + 1)'(cur_old) + 1'b1;
        old_adv = (old_inc == (CNT_W + 1)'(CAPACITY)) ? '0 : SLOT_W'(old_inc);

        walk_inc = (CNT_W + 1)'(walk_slot_reg) + 1'b1;
        walk_adv = (walk_inc == (CNT_W + 1)'(CAPACITY)) ? '0 : SLOT_W'(walk_inc);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.capture)
        begin
            cmd_reg <= req_cmd;
            loc_reg <= req_location;
            lvl_reg <= req_fill_level;
            cls_reg <= req_level_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCATIONS; i++)
            begin
                fill_cnt_reg[i] <= '0;
                oldest_reg[i]   <= '0;
            end
        end
        else if (cmd_in.push_write)
        begin
            if (cnt_full)
            begin
                oldest_reg[loc_idx] <= old_adv;
            end
            else
            begin
                fill_cnt_reg[loc_idx] <= cur_cnt + 1'b1;
            end
        end
    end

    // history memory, one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd_in.push_write)
        begin
            hist_mem[ADDR_W'(base_addr + ADDR_W'(push_slot))] <= {lvl_reg, cls_reg};
        end
        if (cmd_in.walk_step)
        begin
            rd_data_reg <= hist_mem[ADDR_W'(base_addr + ADDR_W'(walk_slot_reg))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            issue_cnt_reg <= '0;
            walk_slot_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd_in.walk_step;
            if (cmd_in.walk_start)
            begin
                issue_cnt_reg <= '0;
                walk_slot_reg <= cur_old;
            end
            else if (cmd_in.walk_step)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                walk_slot_reg <= walk_adv;
            end
        end
    end

    assign rd_class = rd_data_reg[CLS_W-1:0];

    // accumulate sum and class counts
    always_ff @(posedge clk)
    begin
        if (cmd_in.walk_start)
        begin
            sum_reg <= '0;
            red_reg <= '0;
            yel_reg <= '0;
            grn_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg[MEM_W-1:CLS_W]);
            if (rd_class == CLASS_RED)
            begin
                red_reg <= red_reg + 1'b1;
            end
            else if (rd_class == CLASS_YELLOW)
            begin
                yel_reg <= yel_reg + 1'b1;
            end
            else
            begin
                grn_reg <= grn_reg + 1'b1;
            end
        end
    end

    bhls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_in.div_start),
        .dividend (sum_reg),
        .divisor  (cur_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        if (red_reg >= yel_reg && red_reg >= grn_reg)
        begin
            dom = CLASS_RED;
        end
        else if (yel_reg >= grn_reg)
        begin
            dom = CLASS_YELLOW;
        end
        else
        begin
            dom = CLASS_GREEN;
        end

        if (quotient >= TIER_HIGH_MIN)
        begin
            tier = TIER_HIGH;
        end
        else if (quotient >= TIER_MID_MIN)
        begin
            tier = TIER_MID;
        end
        else
        begin
            tier = TIER_LOW;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_in.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.load_out)
        begin
            outcome_reg   <= OUTCOME_DONE;
            count_out_reg <= ENTRY_W'(cur_cnt);
            mean_out_reg  <= '0;
            dom_out_reg   <= CLASS_RED;
            tier_out_reg  <= TIER_LOW;
            if (!in_range)
            begin
                outcome_reg   <= OUTCOME_RANGE;
                count_out_reg <= '0;
            end
            else if (cmd_reg == CMD_ANALYSE)
            begin
                if (cur_cnt == '0)
                begin
                    outcome_reg <= OUTCOME_EMPTY;
                end
                else
                begin
                    mean_out_reg <= quotient;
                    dom_out_reg  <= dom;
                    tier_out_reg <= tier;
                end
            end
        end
    end

    assign stat.in_range  = in_range;
    assign stat.is_push   = (cmd_reg == CMD_PUSH);
    assign stat.cnt_zero  = (cur_cnt == '0);
    assign stat.walk_last = (CNT_W'(issue_cnt_reg + 1'b1) == cur_cnt);
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid          = out_valid_reg;
    assign rsp_outcome        = outcome_reg;
    assign rsp_entry_count    = count_out_reg;
    assign rsp_mean_level     = mean_out_reg;
    assign rsp_dominant_class = dom_out_reg;
    assign rsp_advice_tier    = tier_out_reg;

endmodule

FILE: rtl/bhls_ctrl.sv
module bhls_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bhls_pkg::bhls_stat_t  stat,
    output bhls_pkg::bhls_cmd_t   cmd_out
);
    import bhls_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECIDE   = 3'd1;
    localparam logic [2:0] ST_WALK     = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_DIV_LOAD = 3'd4;
    localparam logic [2:0] ST_DIV_RUN  = 3'd5;
    localparam logic [2:0] ST_RESULT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd_out    = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_out.capture = 1'b1;
                    state_next      = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.in_range)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.is_push)
                begin
                    cmd_out.push_write = 1'b1;
                    state_next         = ST_RESULT;
                end
                else if (stat.cnt_zero)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd_out.walk_start = 1'b1;
                    state_next         = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd_out.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd_out.div_start = 1'b1;
                state_next        = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd_out.load_out = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bounded_history_level_stats.sv
// push, out-of-range and empty requests: DECIDE, then RESULT loads the output register
// analyse of n entries: states WALK, DRAIN, DIV_LOAD, DIV_RUN and RESULT in that order,
// with the one-entry-per-cycle walk of the history memory and the one-bit-per-cycle divider
// next request is taken once the result is in the output register
// async active-low reset empties every location; history memory contents are not cleared
module bounded_history_level_stats (
    input  logic clk,
    input  logic rst_n,
    bhls_req_if.sink   req,
    bhls_rsp_if.source rsp
);
    import bhls_pkg::*;

    bhls_cmd_t  cmd;
    bhls_stat_t stat;

    bhls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd_out   (cmd)
    );

    bhls_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_in             (cmd),
        .stat               (stat),
        .req_cmd            (req.cmd),
        .req_location       (req.location),
        .req_fill_level     (req.fill_level),
        .req_level_class    (req.level_class),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_outcome        (rsp.outcome),
        .rsp_entry_count    (rsp.entry_count),
        .rsp_mean_level     (rsp.mean_level),
        .rsp_dominant_class (rsp.dominant_class),
        .rsp_advice_tier    (rsp.advice_tier)
    );

endmodule
